// File: design/lcec_pkg.sv
// Package for the LRU complete-entry cache table.
// Holds sizes, opcode, status and update codes, and the search record type.
// No dependencies.
package lcec_pkg;

  localparam int ENTRIES  = 16;
  localparam int TAG_BITS = 32;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int STAMP_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int EVICT_W  = 32;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [OP_W-1:0] OP_FIND       = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD        = 2'd1;
  localparam logic [OP_W-1:0] OP_GET_OR_ADD = 2'd2;
  localparam logic [OP_W-1:0] OP_MARK       = 2'd3;

  localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREE       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_STORED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS_DONE  = 3'd4;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_FILL,
    UPD_TOUCH,
    UPD_MARK
  } upd_kind_t;

  typedef struct packed {
    upd_kind_t            kind;
    logic [IDX_W-1:0]     idx;
    logic [TAG_BITS-1:0]  tag;
    logic [STAMP_W-1:0]   stamp;
  } upd_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic                 free;
    logic [IDX_W-1:0]     free_idx;
    logic                 cand;
    logic [IDX_W-1:0]     cand_idx;
    logic [STAMP_W-1:0]   cand_stamp;
    logic [TAG_BITS-1:0]  cand_tag;
  } rec_t;

  localparam rec_t REC_INIT = '0;

endpackage

// File: design/lcec_cell.sv
// One slot of the LRU complete-entry cache table.
// Holds tag, stamp, valid and complete; folds itself into the passing search record.
// Depends on lcec_pkg.
module lcec_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lcec_pkg::IDX_W-1:0]  my_idx,
  input  logic [lcec_pkg::TAG_BITS-1:0] key,
  input  lcec_pkg::rec_t              rec_in,
  output lcec_pkg::rec_t              rec_out,
  input  lcec_pkg::upd_t              upd,
  output logic                        valid_o
);
  import lcec_pkg::*;

  logic                valid_r;
  logic                complete_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [STAMP_W-1:0]  stamp_r;
  rec_t                rec_nxt;
  rec_t                rec_r;
  logic                sel;

  assign sel = (upd.idx == my_idx);

  always_comb begin
    rec_nxt = rec_in;
    if (!rec_in.hit && valid_r && (tag_r == key)) begin
      rec_nxt.hit     = 1'b1;
      rec_nxt.hit_idx = my_idx;
    end
    if (!rec_in.free && !valid_r) begin
      rec_nxt.free     = 1'b1;
      rec_nxt.free_idx = my_idx;
    end
    if (valid_r && complete_r && (!rec_in.cand || (stamp_r < rec_in.cand_stamp))) begin
      rec_nxt.cand       = 1'b1;
      rec_nxt.cand_idx   = my_idx;
      rec_nxt.cand_stamp = stamp_r;
      rec_nxt.cand_tag   = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      complete_r <= 1'b0;
    end else if (sel) begin
      unique case (upd.kind)
        UPD_FILL: begin
          valid_r    <= 1'b1;
          complete_r <= 1'b0;
        end
        UPD_MARK:  complete_r <= 1'b1;
        UPD_TOUCH,
        UPD_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && (upd.kind == UPD_FILL)) begin
      tag_r   <= upd.tag;
      stamp_r <= upd.stamp;
    end else if (sel && (upd.kind == UPD_TOUCH)) begin
      stamp_r <= upd.stamp;
    end
  end

  assign rec_out = rec_r;
  assign valid_o = valid_r;

endmodule

// File: design/lru_complete_entry_cache_table.sv
// Top level of the LRU complete-entry cache table.
// Request capture, scan sequencing and the update decision over a chain of lcec_cell.
// Depends on lcec_pkg and lcec_cell.
//
// For each item the search record walks the chain of slot cells one cell per cycle;
// then the chosen slot is decided and written while the result is registered, and
// busy drops. The result shows on out_valid for exactly one cycle, in the first
// cycle in which busy is low again; the receiver cannot stall it. A new start is
// taken at the edge that ends that cycle.
module lru_complete_entry_cache_table
  import lcec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        in_opcode,
  input  logic [KEY_W-1:0]       in_key_tag,
  input  logic [STAMP_W-1:0]     in_now,
  input  logic [SLOT_W-1:0]      in_target_slot,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [SLOT_W-1:0]      out_slot_index,
  output logic [EVICT_W-1:0]     out_evicted_tag
);

  logic                busy_r;
  logic                out_valid_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [OP_W-1:0]     op_r;
  logic [TAG_BITS-1:0] key_r;
  logic [STAMP_W-1:0]  now_r;
  logic [SLOT_W-1:0]   target_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [EVICT_W-1:0]  evict_r, evict_nxt;

  rec_t                chain [ENTRIES];
  logic [ENTRIES-1:0]  valid_vec;
  rec_t                fin;
  upd_t                upd;
  logic                accept;
  logic                commit;
  logic                tgt_ok;

  assign accept = start && !busy_r;
  assign commit = busy_r && (cnt_r == CNT_W'(ENTRIES));
  assign fin    = chain[ENTRIES-1];

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_first
        lcec_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .my_idx  (IDX_W'(g)),
          .key     (key_r),
          .rec_in  (REC_INIT),
          .rec_out (chain[g]),
          .upd     (upd),
          .valid_o (valid_vec[g])
        );
      end else begin : g_next
        lcec_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .my_idx  (IDX_W'(g)),
          .key     (key_r),
          .rec_in  (chain[g-1]),
          .rec_out (chain[g]),
          .upd     (upd),
          .valid_o (valid_vec[g])
        );
      end
    end
  endgenerate

  assign tgt_ok = (32'(target_r) < ENTRIES) && valid_vec[IDX_W'(target_r)];

  always_comb begin
    upd.kind   = UPD_NONE;
    upd.idx    = '0;
    upd.tag    = key_r;
    upd.stamp  = now_r;
    status_nxt = ST_MISS_DONE;
    slot_nxt   = '0;
    evict_nxt  = '0;
    if (op_r == OP_MARK) begin
      if (tgt_ok) begin
        upd.kind   = UPD_MARK;
        upd.idx    = IDX_W'(target_r);
        status_nxt = ST_MISS_DONE;
        slot_nxt   = target_r;
      end else begin
        status_nxt = ST_NOT_STORED;
      end
    end else if (fin.hit && (op_r != OP_ADD)) begin
      upd.kind   = UPD_TOUCH;
      upd.idx    = fin.hit_idx;
      status_nxt = ST_HIT;
      slot_nxt   = SLOT_W'(fin.hit_idx);
    end else if (op_r == OP_FIND) begin
      status_nxt = ST_MISS_DONE;
    end else if (fin.free) begin
      upd.kind   = UPD_FILL;
      upd.idx    = fin.free_idx;
      status_nxt = ST_FREE;
      slot_nxt   = SLOT_W'(fin.free_idx);
    end else if (fin.cand) begin
      upd.kind   = UPD_FILL;
      upd.idx    = fin.cand_idx;
      status_nxt = ST_REPLACED;
      slot_nxt   = SLOT_W'(fin.cand_idx);
      evict_nxt  = EVICT_W'(fin.cand_tag);
    end else begin
      status_nxt = ST_NOT_STORED;
    end
    if (!commit) begin
      upd.kind = UPD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= commit;
      if (accept) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (commit) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_opcode;
      key_r    <= TAG_BITS'(in_key_tag);
      now_r    <= in_now;
      target_r <= in_target_slot;
    end
    if (commit) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      evict_r  <= evict_nxt;
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot_index  = slot_r;
  assign out_evicted_tag = evict_r;

endmodule
